### design/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int TIME_BITS_DEF = 32;
	localparam int HANDLE_BITS   = 8;

	// operation codes of an input word
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_DEL  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	typedef enum logic [2:0] {
		KIND_OK       = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_DUP      = 3'd2,
		KIND_NOTFOUND = 3'd3,
		KIND_EXPIRED  = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHUP,
		ST_INS,
		ST_SHDN,
		ST_TREAD,
		ST_TCHK,
		ST_TFIN,
		ST_EMIT
	} state_t;

endpackage

### design/sorted_timer_queue.sv
// Sorted timer queue, entries kept in expiry order in one 1R1W RAM; one item at a time.
// Add/delete: scan the entries, then insert the new entry or move each entry that has to shift.
// Tick: on an empty queue only the time advances; else the head is checked and, per expired
// timer, the entries behind it, if any, are moved down and the head is reread.
// Results leave through an output register; a held word stalls.
// Reset clears the entry count, time counter and handshake state; RAM is not cleared.
`timescale 1ns / 1ps

module sorted_timer_queue
	import stq_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  handle,
	input  logic [31:0] delay_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  handle_out,
	output logic        last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = HANDLE_BITS + TIME_BITS;

	state_t               state_q, state_d;
	logic [AW-1:0]        idx_q, idx_d, fpos_q, fpos_d;
	logic [CW-1:0]        pos_q, pos_d, cnt_q, cnt_d;
	logic                 pos_set_q, pos_set_d, found_q, found_d;
	logic                 have_pend_q, have_pend_d;
	logic [1:0]           op_q, op_d;
	logic [7:0]           hnd_q, hnd_d, pend_q, pend_d;
	logic [TIME_BITS-1:0] exp_q, exp_d, time_q, time_d;
	kind_t                res_q, res_d;
	logic                 ov_q, ov_d, last_q, last_d;
	kind_t                kind_q, kind_d;
	logic [7:0]           ho_q, ho_d;

	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [EW-1:0]        wdata, rdata;
	logic [7:0]           rd_h;
	logic [TIME_BITS-1:0] rd_e;
	logic                 can_emit;

	stq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_h     = rdata[TIME_BITS +: HANDLE_BITS];
	assign rd_e     = rdata[TIME_BITS-1:0];
	assign can_emit = !ov_q || out_ready;

	assign out_valid  = ov_q;
	assign kind       = kind_q;
	assign handle_out = ho_q;
	assign last       = last_q;

	// sequence the scan, shift and drain steps
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		fpos_d      = fpos_q;
		pos_d       = pos_q;
		cnt_d       = cnt_q;
		pos_set_d   = pos_set_q;
		found_d     = found_q;
		have_pend_d = have_pend_q;
		op_d        = op_q;
		hnd_d       = hnd_q;
		pend_d      = pend_q;
		exp_d       = exp_q;
		time_d      = time_q;
		res_d       = res_q;
		ov_d        = ov_q && !out_ready;
		kind_d      = kind_q;
		ho_d        = ho_q;
		last_d      = last_q;
		we          = 1'b0;
		waddr       = '0;
		wdata       = rdata;
		raddr       = '0;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d        = op;
					hnd_d       = handle;
					exp_d       = time_q + TIME_BITS'(delay_ticks);
					idx_d       = '0;
					found_d     = 1'b0;
					pos_d       = cnt_q;
					pos_set_d   = 1'b0;
					have_pend_d = 1'b0;
					case (op)
						OP_ADD, OP_DEL: begin
							state_d = (cnt_q == '0) ? ST_DECIDE : ST_SCAN;
						end
						OP_TICK: begin
							time_d  = time_q + 1'b1;
							state_d = (cnt_q == '0) ? ST_IDLE : ST_TCHK;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (rd_h == hnd_q && !found_q) begin
					found_d = 1'b1;
					fpos_d  = idx_q;
				end
				if (!pos_set_q && rd_e >= exp_q) begin
					pos_d     = CW'(idx_q);
					pos_set_d = 1'b1;
				end
				if (CW'(idx_q) == cnt_q - 1'b1) begin
					state_d = ST_DECIDE;
				end else begin
					idx_d = idx_q + 1'b1;
					raddr = idx_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				if (op_q == OP_ADD) begin
					if (found_q) begin
						res_d   = KIND_DUP;
						state_d = ST_EMIT;
					end else if (cnt_q == CW'(CAPACITY)) begin
						res_d   = KIND_FULL;
						state_d = ST_EMIT;
					end else if (pos_q == cnt_q) begin
						state_d = ST_INS;
					end else begin
						idx_d   = AW'(cnt_q - 1'b1);
						raddr   = AW'(cnt_q - 1'b1);
						state_d = ST_SHUP;
					end
				end else if (!found_q) begin
					res_d   = KIND_NOTFOUND;
					state_d = ST_EMIT;
				end else if (CW'(fpos_q) == cnt_q - 1'b1) begin
					cnt_d   = cnt_q - 1'b1;
					res_d   = KIND_OK;
					state_d = ST_EMIT;
				end else begin
					idx_d   = fpos_q + 1'b1;
					raddr   = fpos_q + 1'b1;
					state_d = ST_SHDN;
				end
			end
			// move entries up to open the slot
			ST_SHUP: begin
				we    = 1'b1;
				waddr = idx_q + 1'b1;
				if (CW'(idx_q) == pos_q) begin
					state_d = ST_INS;
				end else begin
					idx_d = idx_q - 1'b1;
					raddr = idx_q - 1'b1;
				end
			end
			ST_INS: begin
				we      = 1'b1;
				waddr   = AW'(pos_q);
				wdata   = {hnd_q, exp_q};
				cnt_d   = cnt_q + 1'b1;
				res_d   = KIND_OK;
				state_d = ST_EMIT;
			end
			// move entries down to close the gap
			ST_SHDN: begin
				we    = 1'b1;
				waddr = idx_q - 1'b1;
				if (CW'(idx_q) == cnt_q - 1'b1) begin
					cnt_d = cnt_q - 1'b1;
					if (op_q == OP_TICK) begin
						state_d = ST_TREAD;
					end else begin
						res_d   = KIND_OK;
						state_d = ST_EMIT;
					end
				end else begin
					idx_d = idx_q + 1'b1;
					raddr = idx_q + 1'b1;
				end
			end
			ST_TREAD: begin
				state_d = ST_TCHK;
			end
			// check the head; hold one expired word back to mark the last
			ST_TCHK: begin
				if (rd_e <= time_q) begin
					if (!(have_pend_q && !can_emit)) begin
						if (have_pend_q) begin
							ov_d   = 1'b1;
							kind_d = KIND_EXPIRED;
							ho_d   = pend_q;
							last_d = 1'b0;
						end
						pend_d      = rd_h;
						have_pend_d = 1'b1;
						if (cnt_q == CW'(1)) begin
							cnt_d   = '0;
							state_d = ST_TFIN;
						end else begin
							idx_d   = AW'(1);
							raddr   = AW'(1);
							state_d = ST_SHDN;
						end
					end
				end else begin
					state_d = ST_TFIN;
				end
			end
			ST_TFIN: begin
				if (!have_pend_q) begin
					state_d = ST_IDLE;
				end else if (can_emit) begin
					ov_d        = 1'b1;
					kind_d      = KIND_EXPIRED;
					ho_d        = pend_q;
					last_d      = 1'b1;
					have_pend_d = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (can_emit) begin
					ov_d    = 1'b1;
					kind_d  = res_q;
					ho_d    = hnd_q;
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			time_q      <= '0;
			ov_q        <= 1'b0;
			have_pend_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			time_q      <= time_d;
			ov_q        <= ov_d;
			have_pend_q <= have_pend_d;
		end
	end

	// working registers and output word
	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		fpos_q    <= fpos_d;
		pos_q     <= pos_d;
		pos_set_q <= pos_set_d;
		found_q   <= found_d;
		op_q      <= op_d;
		hnd_q     <= hnd_d;
		pend_q    <= pend_d;
		exp_q     <= exp_d;
		res_q     <= res_d;
		kind_q    <= kind_d;
		ho_q      <= ho_d;
		last_q    <= last_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op == OP_TICK) |=> time_q == $past(time_q) + 1'b1)
		else $error("tick did not advance time");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q != KIND_EXPIRED) |-> last_q)
		else $error("status word without last");

endmodule

### design/stq_ram.sv
`timescale 1ns / 1ps

module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
